/* src/pp2rgb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pp2rgb_pkg: shared types, constants and helper functions
// Register map codes, datapath widths and the mask analysis and divide-step
// functions used by the packed pixel converter.
// ----------------------------------------------------------------------------
package pp2rgb_pkg;

  localparam int BYTE_W    = 8;
  localparam int PIX_BYTES = 4;
  localparam int PIX_W     = BYTE_W * PIX_BYTES;   // assembled pixel word
  localparam int MUL_W     = PIX_W + BYTE_W;       // channel value times 255
  localparam int DIV_STEPS = MUL_W;                // one quotient bit per stage
  localparam int SHIFT_W   = $clog2(PIX_W);
  localparam int POP_W     = $clog2(PIX_W + 1);
  localparam int BPP_W     = 3;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 2;

  // Register indexes; the byte address is four times the index.
  localparam logic [REG_IDX_W-1:0] REG_BPP   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LSB   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RED   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GREEN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BLUE  = 3'd4;

  localparam logic [BPP_W-1:0] BPP_RESET   = 3'd4;
  localparam logic [PIX_W-1:0] RED_RESET   = 32'h00FF_0000;
  localparam logic [PIX_W-1:0] GREEN_RESET = 32'h0000_FF00;
  localparam logic [PIX_W-1:0] BLUE_RESET  = 32'h0000_00FF;

  // Per-channel values derived from a mask when it is written.
  typedef struct packed {
    logic               zero;     // mask has no set bits
    logic [SHIFT_W-1:0] shift;    // trailing zeros of the mask
    logic [PIX_W-1:0]   divisor;  // 2^width - 1
  } chan_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] rem;
    logic             qbit;
  } div_step_t;

  function automatic logic [POP_W-1:0] popcount(input logic [PIX_W-1:0] m);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < PIX_W; i++) begin
      c = c + POP_W'(m[i]);
    end
    return c;
  endfunction

  function automatic logic [SHIFT_W-1:0] trailing_zeros(input logic [PIX_W-1:0] m);
    logic [SHIFT_W-1:0] s;
    s = '0;
    for (int i = PIX_W - 1; i >= 0; i--) begin
      if (m[i]) begin
        s = SHIFT_W'(i);
      end
    end
    return s;
  endfunction

  function automatic chan_cfg_t derive_chan(input logic [PIX_W-1:0] m);
    chan_cfg_t       c;
    logic [PIX_W:0]  ones;
    ones      = ({{PIX_W{1'b0}}, 1'b1} << popcount(m)) - {{PIX_W{1'b0}}, 1'b1};
    c.zero    = (m == '0);
    c.shift   = trailing_zeros(m);
    c.divisor = ones[PIX_W-1:0];
    return c;
  endfunction

  // One restoring division step: bring in the next numerator bit and
  // subtract the divisor when it fits.
  function automatic div_step_t div_step(input logic [PIX_W-1:0] rem,
                                         input logic             nbit,
                                         input logic [PIX_W-1:0] divisor);
    div_step_t      r;
    logic [PIX_W:0] trial;
    logic [PIX_W:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      r.rem  = diff[PIX_W-1:0];
      r.qbit = 1'b1;
    end else begin
      r.rem  = trial[PIX_W-1:0];
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/pp2rgb_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pp2rgb_div: pipelined restoring divider
// One quotient bit per register stage; only the low eight quotient bits are
// kept, since the channel output is the quotient modulo 256.
// ----------------------------------------------------------------------------
module pp2rgb_div (
  input  wire logic                          clk,
  input  wire logic                          ce,
  input  wire logic [pp2rgb_pkg::MUL_W-1:0]  num,
  input  wire logic [pp2rgb_pkg::PIX_W-1:0]  divisor,
  output logic      [pp2rgb_pkg::BYTE_W-1:0] quot
);

  localparam int STEPS = pp2rgb_pkg::DIV_STEPS;
  localparam int MW    = pp2rgb_pkg::MUL_W;
  localparam int QW    = pp2rgb_pkg::BYTE_W;

  // The last stage only produces its quotient bit, so remainder and
  // numerator are held for all stages but the last.
  logic [pp2rgb_pkg::PIX_W-1:0] rem_r [STEPS-1];
  logic [MW-1:0]                num_r [STEPS-1];
  logic [QW-1:0]                q_r   [STEPS];
  pp2rgb_pkg::div_step_t        res   [STEPS];

  always_comb begin
    res[0] = pp2rgb_pkg::div_step('0, num[MW-1], divisor);
    for (int s = 1; s < STEPS; s++) begin
      res[s] = pp2rgb_pkg::div_step(rem_r[s-1], num_r[s-1][MW-1], divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= res[0].rem;
      num_r[0] <= {num[MW-2:0], 1'b0};
      q_r[0]   <= {{(QW-1){1'b0}}, res[0].qbit};
      for (int s = 1; s < STEPS - 1; s++) begin
        rem_r[s] <= res[s].rem;
        num_r[s] <= {num_r[s-1][MW-2:0], 1'b0};
      end
      for (int s = 1; s < STEPS; s++) begin
        q_r[s] <= {q_r[s-1][QW-2:0], res[s].qbit};
      end
    end
  end

  assign quot = q_r[STEPS-1];

endmodule
`default_nettype wire

/* src/packed_pixel_to_rgb888.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// packed_pixel_to_rgb888: packed pixel to 8-bit RGB converter
// Assembles a 1 to 4 byte pixel word and scales each masked channel to
// eight bits through a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock while in_stall is low and returns
// one RGB beat per pixel, in order. The datapath: one stage assembles the
// pixel word, one masks and shifts each channel down, one multiplies the
// channel by 255, and a 40-stage restoring divider per channel produces one
// quotient bit per stage, dividing by 2^width - 1 of the channel mask. The
// last divider stage is the output register. A stall on a valid output beat
// freezes the whole pipeline and raises in_stall in the same cycle, so
// nothing is lost or repeated. Mask shift, width and divisor are derived
// when a mask register is written, so a configuration write takes effect for
// the very next pixel; the user must write registers only while no pixel is
// in flight, and the block itself does not enforce this.
// Register map (byte address): 0x00 bytes per pixel (values above four
// act as four, zero yields an all-zero word), 0x04 byte order (1 = first
// byte least significant), 0x08 red mask, 0x0C green mask, 0x10 blue mask.
// A channel whose mask is zero reads as zero.
// ----------------------------------------------------------------------------
module packed_pixel_to_rgb888 (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Pixel input.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [pp2rgb_pkg::PIX_W-1:0]      in_raw_bytes,
  // RGB output.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic      [pp2rgb_pkg::BYTE_W-1:0]     out_red,
  output logic      [pp2rgb_pkg::BYTE_W-1:0]     out_green,
  output logic      [pp2rgb_pkg::BYTE_W-1:0]     out_blue,
  // Configuration port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pp2rgb_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [pp2rgb_pkg::PIX_W-1:0]      pwdata,
  output logic      [pp2rgb_pkg::PIX_W-1:0]      prdata,
  output logic                                   pready
);

  localparam int PW    = pp2rgb_pkg::PIX_W;
  localparam int MW    = pp2rgb_pkg::MUL_W;
  localparam int BW    = pp2rgb_pkg::BYTE_W;
  localparam int BPPW  = pp2rgb_pkg::BPP_W;
  // Stages ahead of the divider: word assembly, mask and shift, multiply.
  localparam int FRONT = 3;
  localparam int DEPTH = FRONT + pp2rgb_pkg::DIV_STEPS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [BPPW-1:0]           bpp_r;
  logic                      lsb_first_r;
  logic [PW-1:0]             red_mask_r;
  logic [PW-1:0]             green_mask_r;
  logic [PW-1:0]             blue_mask_r;
  pp2rgb_pkg::chan_cfg_t     red_cfg_r;
  pp2rgb_pkg::chan_cfg_t     green_cfg_r;
  pp2rgb_pkg::chan_cfg_t     blue_cfg_r;

  logic [pp2rgb_pkg::REG_IDX_W-1:0] reg_idx;
  logic                             cfg_wr;

  assign reg_idx = paddr[pp2rgb_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Writes to addresses past the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r        <= pp2rgb_pkg::BPP_RESET;
      lsb_first_r  <= 1'b1;
      red_mask_r   <= pp2rgb_pkg::RED_RESET;
      green_mask_r <= pp2rgb_pkg::GREEN_RESET;
      blue_mask_r  <= pp2rgb_pkg::BLUE_RESET;
      red_cfg_r    <= pp2rgb_pkg::derive_chan(pp2rgb_pkg::RED_RESET);
      green_cfg_r  <= pp2rgb_pkg::derive_chan(pp2rgb_pkg::GREEN_RESET);
      blue_cfg_r   <= pp2rgb_pkg::derive_chan(pp2rgb_pkg::BLUE_RESET);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pp2rgb_pkg::REG_BPP: begin
          bpp_r <= pwdata[BPPW-1:0];
        end
        pp2rgb_pkg::REG_LSB: begin
          lsb_first_r <= pwdata[0];
        end
        pp2rgb_pkg::REG_RED: begin
          red_mask_r <= pwdata;
          red_cfg_r  <= pp2rgb_pkg::derive_chan(pwdata);
        end
        pp2rgb_pkg::REG_GREEN: begin
          green_mask_r <= pwdata;
          green_cfg_r  <= pp2rgb_pkg::derive_chan(pwdata);
        end
        pp2rgb_pkg::REG_BLUE: begin
          blue_mask_r <= pwdata;
          blue_cfg_r  <= pp2rgb_pkg::derive_chan(pwdata);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pp2rgb_pkg::REG_BPP:   prdata = {{(PW-BPPW){1'b0}}, bpp_r};
      pp2rgb_pkg::REG_LSB:   prdata = {{(PW-1){1'b0}}, lsb_first_r};
      pp2rgb_pkg::REG_RED:   prdata = red_mask_r;
      pp2rgb_pkg::REG_GREEN: prdata = green_mask_r;
      pp2rgb_pkg::REG_BLUE:  prdata = blue_mask_r;
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole pipeline advances unless a finished beat
  // sits in the output register and is stalled.
  // ---------------------------------------------------------------------------
  logic             ce;
  logic [DEPTH-1:0] valid_r;

  assign ce        = !(valid_r[DEPTH-1] && out_stall);
  assign in_stall  = !ce;
  assign out_valid = valid_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ce) begin
      valid_r <= {valid_r[DEPTH-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: pixel word assembly. Bytes past the pixel size are dropped; in
  // most-significant-first order the first byte lands at the top of the
  // used bytes.
  // ---------------------------------------------------------------------------
  logic [BPPW-1:0] n_bytes;
  logic [PW-1:0]   word_nxt;
  logic [PW-1:0]   word_r;
  logic [BW-1:0]   b0, b1, b2, b3;

  assign b0 = in_raw_bytes[BW-1:0];
  assign b1 = in_raw_bytes[2*BW-1:BW];
  assign b2 = in_raw_bytes[3*BW-1:2*BW];
  assign b3 = in_raw_bytes[4*BW-1:3*BW];

  assign n_bytes = (bpp_r > BPPW'(pp2rgb_pkg::PIX_BYTES)) ?
                   BPPW'(pp2rgb_pkg::PIX_BYTES) : bpp_r;

  always_comb begin
    unique case (n_bytes)
      3'd1:    word_nxt = {24'd0, b0};
      3'd2:    word_nxt = lsb_first_r ? {16'd0, b1, b0} : {16'd0, b0, b1};
      3'd3:    word_nxt = lsb_first_r ? {8'd0, b2, b1, b0} : {8'd0, b0, b1, b2};
      3'd4:    word_nxt = lsb_first_r ? {b3, b2, b1, b0} : {b0, b1, b2, b3};
      default: word_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      word_r <= word_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: mask each channel and shift it down to bit zero.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] red_val_r, green_val_r, blue_val_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      red_val_r   <= (word_r & red_mask_r)   >> red_cfg_r.shift;
      green_val_r <= (word_r & green_mask_r) >> green_cfg_r.shift;
      blue_val_r  <= (word_r & blue_mask_r)  >> blue_cfg_r.shift;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: multiply by 255 as value * 256 - value.
  // ---------------------------------------------------------------------------
  logic [MW-1:0] red_prod_r, green_prod_r, blue_prod_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      red_prod_r   <= {red_val_r, {BW{1'b0}}}   - {{BW{1'b0}}, red_val_r};
      green_prod_r <= {green_val_r, {BW{1'b0}}} - {{BW{1'b0}}, green_val_r};
      blue_prod_r  <= {blue_val_r, {BW{1'b0}}}  - {{BW{1'b0}}, blue_val_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: product / (2^width - 1), low eight quotient bits. Even
  // a non-contiguous mask, whose shifted value can exceed the divisor, gets
  // the exact quotient. The divisor comes straight from the config registers;
  // the user must hold them steady while pixels are in flight (not enforced).
  // ---------------------------------------------------------------------------
  logic [BW-1:0] red_q, green_q, blue_q;

  pp2rgb_div u_div_red (
    .clk     (clk),
    .ce      (ce),
    .num     (red_prod_r),
    .divisor (red_cfg_r.divisor),
    .quot    (red_q)
  );

  pp2rgb_div u_div_green (
    .clk     (clk),
    .ce      (ce),
    .num     (green_prod_r),
    .divisor (green_cfg_r.divisor),
    .quot    (green_q)
  );

  pp2rgb_div u_div_blue (
    .clk     (clk),
    .ce      (ce),
    .num     (blue_prod_r),
    .divisor (blue_cfg_r.divisor),
    .quot    (blue_q)
  );

  // A zero mask has no divisor; its channel is forced to zero.
  assign out_red   = red_cfg_r.zero   ? '0 : red_q;
  assign out_green = green_cfg_r.zero ? '0 : green_q;
  assign out_blue  = blue_cfg_r.zero  ? '0 : blue_q;

endmodule
`default_nettype wire

/* test/tb_packed_pixel_to_rgb888.sv */
// ----------------------------------------------------------------------------
// tb_packed_pixel_to_rgb888: self-checking testbench for the pixel converter
// Drives packed pixels under random burst gaps and output stalls, programs the
// format registers over the APB port between phases, and compares every RGB
// beat against a cycle-free model of the byte assembly and channel scaling.
// ----------------------------------------------------------------------------
module tb_packed_pixel_to_rgb888;

  localparam int BYTE_W    = pp2rgb_pkg::BYTE_W;
  localparam int PIX_W     = pp2rgb_pkg::PIX_W;
  localparam int PIX_BYTES = pp2rgb_pkg::PIX_BYTES;
  localparam int ADDR_W    = pp2rgb_pkg::ADDR_W;
  localparam int BPP_W     = pp2rgb_pkg::BPP_W;
  localparam int REG_IDX_W = pp2rgb_pkg::REG_IDX_W;

  // The run is stopped by the watchdog long after the slowest correct run
  // would have ended.
  localparam int CYCLE_LIMIT   = 300000;
  // The datapath is 43 stages deep; a drained pipeline is given slack before
  // registers move, and the end of the run waits for stray beats.
  localparam int DRAIN_SLACK   = 8;
  localparam int TAIL_CYCLES   = 60;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PIXELS  = 100;
  localparam logic [REG_IDX_W-1:0] REG_IDX_LAST = '1;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  // Output stall patterns that the receiver cycles through.
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

  // Pixel formats used to pick register settings for the random phases.
  typedef enum int {
    FMT_RGB888, FMT_BGR888, FMT_RGB565, FMT_RGB555, FMT_RGB332,
    FMT_FIELD_MASKS, FMT_ANY_MASKS
  } pixel_format_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [PIX_W-1:0]    in_raw_bytes;
  logic                out_valid;
  logic                out_stall;
  logic [BYTE_W-1:0]   out_red;
  logic [BYTE_W-1:0]   out_green;
  logic [BYTE_W-1:0]   out_blue;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [PIX_W-1:0]    pwdata;
  logic [PIX_W-1:0]    prdata;
  logic                pready;

  // Shadow copy of the format registers, updated when a write completes.
  logic [BPP_W-1:0]    pix_bytes;
  logic                first_is_lsb;
  logic [PIX_W-1:0]    red_bits;
  logic [PIX_W-1:0]    green_bits;
  logic [PIX_W-1:0]    blue_bits;

  // RGB beats predicted for accepted pixels, oldest first.
  rgb_t                rgb_expected[$];
  int                  error_count;
  int                  cycle_count;
  int                  burst_left;
  bit                  long_hold_req;

  packed_pixel_to_rgb888 u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_raw_bytes (in_raw_bytes),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Builds the pixel word from the first bytes in memory order. A byte count
  // of zero takes no bytes at all, and counts above four act as four.
  function automatic logic [PIX_W-1:0] assemble_word(input logic [PIX_W-1:0] raw);
    int               nbytes;
    logic [PIX_W-1:0] word;
    nbytes = (pix_bytes > PIX_BYTES) ? PIX_BYTES : int'(pix_bytes);
    word   = '0;
    for (int k = 0; k < nbytes; k++) begin
      if (first_is_lsb) begin
        word[BYTE_W*k +: BYTE_W] = raw[BYTE_W*k +: BYTE_W];
      end else begin
        word[BYTE_W*(nbytes-1-k) +: BYTE_W] = raw[BYTE_W*k +: BYTE_W];
      end
    end
    return word;
  endfunction

  // Scales one masked channel to eight bits. The shifted value may exceed the
  // full scale when the mask has holes in it; the quotient is then wider than
  // eight bits and only its low byte survives.
  function automatic logic [BYTE_W-1:0] scale_to_byte(input logic [PIX_W-1:0] word,
                                                      input logic [PIX_W-1:0] mask);
    longint unsigned level;
    longint unsigned full_scale;
    longint unsigned quotient;
    int              lowest;
    if (mask == '0) begin
      return '0;
    end
    lowest = 0;
    while (!mask[lowest]) begin
      lowest++;
    end
    level      = longint'(word & mask) >> lowest;
    full_scale = (64'd1 << $countones(mask)) - 64'd1;
    quotient   = (level * 64'd255) / full_scale;
    return quotient[BYTE_W-1:0];
  endfunction

  function automatic rgb_t pixel_to_rgb(input logic [PIX_W-1:0] raw);
    rgb_t             rgb;
    logic [PIX_W-1:0] word;
    word      = assemble_word(raw);
    rgb.red   = scale_to_byte(word, red_bits);
    rgb.green = scale_to_byte(word, green_bits);
    rgb.blue  = scale_to_byte(word, blue_bits);
    return rgb;
  endfunction

  // Mirrors a register write. Indexes past the blue mask hit no register.
  function automatic void apply_register(input logic [REG_IDX_W-1:0] idx,
                                         input logic [PIX_W-1:0]     data);
    case (idx)
      pp2rgb_pkg::REG_BPP:   pix_bytes    = data[BPP_W-1:0];
      pp2rgb_pkg::REG_LSB:   first_is_lsb = data[0];
      pp2rgb_pkg::REG_RED:   red_bits     = data;
      pp2rgb_pkg::REG_GREEN: green_bits   = data;
      pp2rgb_pkg::REG_BLUE:  blue_bits    = data;
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Idle input cycles; the payload wanders while valid is low.
  task automatic pause_input(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      in_raw_bytes <= $urandom();
    end
  endtask

  // Stops offering pixels and waits until every predicted beat has come back.
  // The pipeline is then empty, so registers may be rewritten.
  task automatic wait_for_drain();
    pause_input(1);
    while (rgb_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // APB write: a setup phase, then an access phase that completes on the
  // rising edge where pready is seen high. The pipeline is emptied first so
  // that no pixel in flight sees the register change.
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [PIX_W-1:0]     data);
    wait_for_drain();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(idx, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_format(input logic [BPP_W-1:0] nbytes, input logic lsb,
                              input logic [PIX_W-1:0] red, input logic [PIX_W-1:0] green,
                              input logic [PIX_W-1:0] blue);
    write_register(pp2rgb_pkg::REG_BPP, PIX_W'(nbytes));
    write_register(pp2rgb_pkg::REG_LSB, PIX_W'(lsb));
    write_register(pp2rgb_pkg::REG_RED, red);
    write_register(pp2rgb_pkg::REG_GREEN, green);
    write_register(pp2rgb_pkg::REG_BLUE, blue);
  endtask

  // Offers one pixel beat and holds it until the block takes it. Valid is left
  // high so that back-to-back beats need no idle gap between them.
  task automatic send_pixel(input logic [PIX_W-1:0] raw);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_raw_bytes <= raw;
    do @(posedge clk); while (in_stall);
    rgb_expected.push_back(pixel_to_rgb(raw));
  endtask

  // Sends one pixel inside the random burst pattern: bursts of random length,
  // most of them preceded by a random gap and some running straight on.
  task automatic send_in_bursts(input logic [PIX_W-1:0] raw);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        pause_input($urandom_range(1, 8));
      end
    end
    send_pixel(raw);
    burst_left--;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset formats are 32-bit words with 8-bit red, green and blue fields.
  task automatic test_reset_format();
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h00A5_5A3C);
    send_pixel(32'h8080_8080);
    wait_for_drain();
  endtask

  // Byte counts zero to three, five and seven, both byte orders. Zero bytes
  // yield an all-zero word, and counts above four saturate at four.
  task automatic test_byte_order();
    write_format(3'd3, 1'b0, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
    send_pixel(32'h9911_2233);
    write_format(3'd2, 1'b0, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F);
    send_pixel(32'h5A5A_1F8C);
    write_register(pp2rgb_pkg::REG_LSB, 32'd1);
    send_pixel(32'hA5A5_1F8C);
    write_format(3'd1, 1'b1, 32'h0000_00E0, 32'h0000_001C, 32'h0000_0003);
    send_pixel(32'hFFFF_FF6D);
    write_format(3'd0, 1'b1, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
    send_pixel(32'hFFFF_FFFF);
    write_format(3'd7, 1'b0, 32'hFF00_0000, 32'h00FF_0000, 32'h0000_00FF);
    send_pixel(32'h1234_5678);
    write_register(pp2rgb_pkg::REG_BPP, 32'd5);
    send_pixel(32'h89AB_CDEF);
    wait_for_drain();
  endtask

  // Zero, full-width, single-bit and holed masks.
  task automatic test_mask_shapes();
    write_format(3'd4, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8000_0000);
    send_pixel(32'h7FFF_FFFF);
    write_format(3'd4, 1'b1, 32'hAAAA_AAAA, 32'h0F0F_0000, 32'h0000_0001);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h5555_5555);
    send_pixel(32'hAAAA_AAAA);
    send_pixel(32'h0A0F_0001);
    wait_for_drain();
  endtask

  // Writes to indexes past the last register must leave the format alone.
  task automatic test_unused_registers();
    write_format(3'd4, 1'b1, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
    for (int idx = pp2rgb_pkg::REG_BLUE + 1; idx <= REG_IDX_LAST; idx++) begin
      write_register(REG_IDX_W'(idx), 32'hFFFF_FFFF);
    end
    send_pixel(32'h0012_34FE);
    send_pixel(32'hFF80_7F01);
    wait_for_drain();
  endtask

  // Random formats, a hundred pixels each, sent in bursts under random output
  // stalls. The byte count mostly matches the format but is sometimes any
  // value the register holds.
  task automatic test_random_formats();
    pixel_format_t    fmt;
    logic [BPP_W-1:0] nbytes;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [63:0]      field;
    logic [PIX_W-1:0] raw;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      fmt = pixel_format_t'($urandom_range(FMT_RGB888, FMT_ANY_MASKS));
      case (fmt)
        FMT_RGB888: begin
          nbytes = BPP_W'($urandom_range(3, 4));
          red = 32'h00FF_0000; green = 32'h0000_FF00; blue = 32'h0000_00FF;
        end
        FMT_BGR888: begin
          nbytes = BPP_W'($urandom_range(3, 4));
          red = 32'h0000_00FF; green = 32'h0000_FF00; blue = 32'h00FF_0000;
        end
        FMT_RGB565: begin
          nbytes = 3'd2;
          red = 32'h0000_F800; green = 32'h0000_07E0; blue = 32'h0000_001F;
        end
        FMT_RGB555: begin
          nbytes = 3'd2;
          red = 32'h0000_7C00; green = 32'h0000_03E0; blue = 32'h0000_001F;
        end
        FMT_RGB332: begin
          nbytes = 3'd1;
          red = 32'h0000_00E0; green = 32'h0000_001C; blue = 32'h0000_0003;
        end
        FMT_FIELD_MASKS: begin
          // Contiguous fields of any width and position.
          nbytes = 3'd4;
          field = ((64'd1 << $urandom_range(0, 32)) - 64'd1) << $urandom_range(0, 31);
          red   = field[PIX_W-1:0];
          field = ((64'd1 << $urandom_range(0, 32)) - 64'd1) << $urandom_range(0, 31);
          green = field[PIX_W-1:0];
          field = ((64'd1 << $urandom_range(0, 32)) - 64'd1) << $urandom_range(0, 31);
          blue  = field[PIX_W-1:0];
        end
        default: begin
          nbytes = BPP_W'($urandom_range(0, 7));
          red = $urandom(); green = $urandom(); blue = $urandom();
        end
      endcase
      if ($urandom_range(0, 4) == 0) begin
        nbytes = BPP_W'($urandom_range(0, 7));
      end
      write_format(nbytes, 1'($urandom_range(0, 1)), red, green, blue);
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        case ($urandom_range(0, 15))
          0:       raw = '0;
          1:       raw = '1;
          default: raw = $urandom();
        endcase
        send_in_bursts(raw);
      end
      wait_for_drain();
    end
  endtask

  // The receiver holds off for a long stretch while pixels are offered back to
  // back, so the pipeline fills and the input must stall.
  task automatic test_backpressure();
    write_format(3'd4, 1'b0, 32'hFF00_0000, 32'h00FF_0000, 32'h0000_FF00);
    long_hold_req = 1'b1;
    for (int n = 0; n < 150; n++) begin
      send_pixel($urandom());
    end
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: walks through stall patterns of random length, including stretches
  // without any stall, and serves a long hold when a test asks for one.
  // ---------------------------------------------------------------------------
  initial begin
    stall_mode_t mode;
    int          stretch;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode    = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
        stretch = $urandom_range(1, 40);
        repeat (stretch) begin
          @(negedge clk);
          case (mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
            default:     out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every beat taken from the block is matched against the
  // oldest prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_rgb
    rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_expected.size() == 0) begin
        $error("unexpected RGB beat: red %0d green %0d blue %0d",
               out_red, out_green, out_blue);
        error_count++;
      end else begin
        want = rgb_expected.pop_front();
        if (out_red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_red);
          error_count++;
        end
        if (out_green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_green);
          error_count++;
        end
        if (out_blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_blue);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Reset is asserted at the start and released on a falling
  // edge; the shadow registers start from the reset values of the block.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_raw_bytes = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    error_count  = 0;
    burst_left   = 0;
    long_hold_req = 1'b0;
    pix_bytes    = pp2rgb_pkg::BPP_RESET;
    first_is_lsb = 1'b1;
    red_bits     = pp2rgb_pkg::RED_RESET;
    green_bits   = pp2rgb_pkg::GREEN_RESET;
    blue_bits    = pp2rgb_pkg::BLUE_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_format();
    test_byte_order();
    test_mask_shapes();
    test_unused_registers();
    test_random_formats();
    test_backpressure();

    // Anything the block emits after the last prediction is caught here.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rgb_expected.size() != 0) begin
      $error("%0d RGB beats never arrived", rgb_expected.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
